[design/cme_pkg.sv]
// ----------------------------------------------------------------------------
// cme_pkg
// Shared types, constants and command codes of the correlation matrix engine.
// ----------------------------------------------------------------------------
package cme_pkg;

   localparam int MAX_MODES   = 8;
   localparam int MAX_SAMPLES = 65536;
   localparam int AMP_WIDTH   = 16;

   localparam int MODE_W  = $clog2(MAX_MODES);
   localparam int MCNT_W  = MODE_W + 1;
   localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W   = 33;
   localparam int PSUM_W  = 48;
   localparam int PHALF_W = PSUM_W / 2;
   localparam int COV_W   = 64;
   localparam int ROOT_W  = COV_W / 2;
   localparam int MUL_W   = 34;
   localparam int CORR_W  = 16;
   localparam int STEP_W  = 5;
   localparam int ISQ_STEPS = ROOT_W;
   localparam int DIV_STEPS = 15;
   localparam int ADDR_W  = 2 * MODE_W;

   localparam logic [CORR_W-1:0] CORR_ONE = CORR_W'(16384);

   typedef struct packed {
      logic signed [AMP_WIDTH-1:0] amplitude;
      logic                        end_of_data;
   } req_type;

   typedef struct packed {
      logic [2:0]               row;
      logic [2:0]               column;
      logic signed [CORR_W-1:0] correlation;
      logic                     zero_variance;
      logic                     last;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_MAC_RD, OP_MAC_WR,
      OP_COV_RD, OP_COV_LO, OP_COV_HI, OP_COV_SS, OP_COV_SUB,
      OP_ISQ_LOAD, OP_ISQ_STEP, OP_ISQ_STORE,
      OP_DMUL, OP_DIV_LOAD, OP_DIV_STEP, OP_EMIT, OP_CLEAR
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_MAC_RD, ST_MAC_WR,
      ST_COV_RD, ST_COV_LO, ST_COV_HI, ST_COV_SS, ST_COV_SUB,
      ST_ISQ_LOAD, ST_ISQ_STEP, ST_ISQ_STORE,
      ST_DMUL, ST_DIV_LOAD, ST_DIV_STEP, ST_EMIT, ST_CLEAR
   } state_type;

   typedef struct packed {
      op_type            op;
      logic [MODE_W-1:0] row;
      logic [MODE_W-1:0] col;
   } cmd_type;

   typedef struct packed {
      logic              complete;
      logic              saturated;
      logic              end_flag;
      logic [MCNT_W-1:0] modes;
   } status_type;

endpackage

[design/correlation_matrix_engine.sv]
// ----------------------------------------------------------------------------
// correlation_matrix_engine
// Pearson correlation matrix of signed Q3.12 mode amplitudes, Q1.14 results.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: drive req_data and raise start; the beat is taken on the edge
//    where start is high and busy is low. Amplitudes arrive mode by mode;
//    mode_count of them form one sample vector.
//  - Config: csr_we/csr_wdata write mode_count (reset 8); write it only idle.
//  - Results: one beat per matrix entry, row-major, on rsp_data for a single
//    cycle marked by rsp_valid; the receiver cannot stall, so take each beat.
//  - Accumulation: a non-closing element is stored. An element closing a
//    vector (sample count not saturated) runs the shared multiply-accumulate
//    over all m*m pairs, read then write back; busy blocks new elements.
//  - End of data: m diagonal passes (covariance, 32-step root), then m*m
//    entries (covariance, multiply, 15-step divide, emit), then a clearing
//    step that clears the sums for the next data set.
//  - Reset: synchronous, clears counts, sums and valid bits of the
//    cross-product memory; the block is ready on the next cycle.
// ----------------------------------------------------------------------------
module correlation_matrix_engine import cme_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [3:0] csr_wdata
);

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   cme_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   cme_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[design/cme_ctrl.sv]
// ----------------------------------------------------------------------------
// cme_ctrl
// Sequencer: accumulation loop, covariance, square root, division, emit.
// ----------------------------------------------------------------------------
module cme_ctrl import cme_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  status_type status,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [MODE_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [STEP_W-1:0] k_ff, k_in;
   logic              diag_ff, diag_in, end_ff, end_in;
   logic [MODE_W-1:0] top_idx;
   logic              i_top, j_top;

   assign top_idx = MODE_W'(status.modes - MCNT_W'(1));
   assign i_top   = (i_ff == top_idx);
   assign j_top   = (j_ff == top_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         diag_ff  <= 1'b0;
         end_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         diag_ff  <= diag_in;
         end_ff   <= end_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      diag_in  = diag_ff;
      end_in   = end_ff;
      cmd.op   = OP_NONE;
      cmd.row  = i_ff;
      cmd.col  = j_ff;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.op = OP_LOAD;
               end_in = status.end_flag;
               i_in   = '0;
               j_in   = '0;
               if (status.complete && !status.saturated) begin
                  state_in = ST_MAC_RD;
               end else if (status.end_flag) begin
                  diag_in  = 1'b1;
                  state_in = ST_COV_RD;
               end
            end
         end
         ST_MAC_RD: begin
            cmd.op   = OP_MAC_RD;
            state_in = ST_MAC_WR;
         end
         ST_MAC_WR: begin
            cmd.op   = OP_MAC_WR;
            state_in = ST_MAC_RD;
            if (j_top) begin
               j_in = '0;
               if (i_top) begin
                  i_in = '0;
                  if (end_ff) begin
                     diag_in  = 1'b1;
                     state_in = ST_COV_RD;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_COV_RD: begin
            cmd.op   = OP_COV_RD;
            state_in = ST_COV_LO;
         end
         ST_COV_LO: begin
            cmd.op   = OP_COV_LO;
            state_in = ST_COV_HI;
         end
         ST_COV_HI: begin
            cmd.op   = OP_COV_HI;
            state_in = ST_COV_SS;
         end
         ST_COV_SS: begin
            cmd.op   = OP_COV_SS;
            state_in = ST_COV_SUB;
         end
         ST_COV_SUB: begin
            cmd.op   = OP_COV_SUB;
            state_in = diag_ff ? ST_ISQ_LOAD : ST_DMUL;
         end
         ST_ISQ_LOAD: begin
            cmd.op   = OP_ISQ_LOAD;
            k_in     = '0;
            state_in = ST_ISQ_STEP;
         end
         ST_ISQ_STEP: begin
            cmd.op = OP_ISQ_STEP;
            k_in   = k_ff + 1'b1;
            if (k_ff == STEP_W'(ISQ_STEPS - 1)) begin
               state_in = ST_ISQ_STORE;
            end
         end
         ST_ISQ_STORE: begin
            cmd.op   = OP_ISQ_STORE;
            state_in = ST_COV_RD;
            if (i_top) begin
               diag_in = 1'b0;
               i_in    = '0;
               j_in    = '0;
            end else begin
               i_in = i_ff + 1'b1;
               j_in = i_ff + 1'b1;
            end
         end
         ST_DMUL: begin
            cmd.op   = OP_DMUL;
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.op   = OP_DIV_LOAD;
            k_in     = '0;
            state_in = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            cmd.op = OP_DIV_STEP;
            k_in   = k_ff + 1'b1;
            if (k_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.op   = OP_EMIT;
            state_in = ST_COV_RD;
            if (j_top) begin
               j_in = '0;
               if (i_top) begin
                  state_in = ST_CLEAR;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_CLEAR: begin
            cmd.op   = OP_CLEAR;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[design/cme_datapath.sv]
// ----------------------------------------------------------------------------
// cme_datapath
// Sums, cross-product memory, shared multiplier, root and divide registers.
// ----------------------------------------------------------------------------
module cme_datapath import cme_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata,
   input  req_type     req_data,
   input  cmd_type     cmd,
   output status_type  status,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   logic [3:0]                 mode_ff;
   logic [MODE_W-1:0]          idx_ff;
   logic [COUNT_W-1:0]         count_ff;
   logic signed [AMP_WIDTH-1:0] vs_ff [MAX_MODES];
   logic signed [SUM_W-1:0]    sum_ff [MAX_MODES];
   logic signed [PSUM_W-1:0]   psum_mem [MAX_MODES*MAX_MODES];
   logic [MAX_MODES*MAX_MODES-1:0] vld_ff;
   logic signed [PSUM_W-1:0]   rd_data_ff;
   logic                       rd_vld_ff;
   logic signed [2*MUL_W-1:0]  mul_ff;
   logic [COV_W-1:0]           acc_ff;
   logic [COV_W-1:0]           rad_ff;
   logic [ROOT_W-1:0]          root_ff;
   logic [ROOT_W+2:0]          srem_ff;
   logic                       isq_ok_ff;
   logic [ROOT_W-1:0]          amp_root_ff [MAX_MODES];
   logic [MAX_MODES-1:0]       diag_ok_ff;
   logic [COV_W-1:0]           div_ff, drem_ff;
   logic [DIV_STEPS-1:0]       q_ff;
   logic                       neg_ff, big_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_ff;

   logic [MCNT_W-1:0]          modes;
   logic [ADDR_W-1:0]          addr;
   logic signed [PSUM_W-1:0]   pval;
   logic signed [MUL_W-1:0]    mul_a, mul_b;
   logic [ROOT_W+2:0]          srem_sh, strial;
   logic [COV_W:0]             drem_sh;
   logic [COV_W-1:0]           mag;
   logic [CORR_W-1:0]          mq;
   logic                       ok;

   always_comb begin
      if (mode_ff == 4'd0) begin
         modes = MCNT_W'(1);
      end else if (mode_ff > 4'(MAX_MODES)) begin
         modes = MCNT_W'(MAX_MODES);
      end else begin
         modes = MCNT_W'(mode_ff);
      end
   end

   assign status.modes     = modes;
   assign status.complete  = ({1'b0, idx_ff} + MCNT_W'(1)) >= modes;
   assign status.saturated = (count_ff == COUNT_W'(MAX_SAMPLES));
   assign status.end_flag  = req_data.end_of_data;

   assign addr = {cmd.row, cmd.col};
   assign pval = rd_vld_ff ? rd_data_ff : '0;

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MAC_RD: begin
            mul_a = MUL_W'(vs_ff[cmd.row]);
            mul_b = MUL_W'(vs_ff[cmd.col]);
         end
         OP_COV_LO: begin
            mul_a = {{(MUL_W-COUNT_W){1'b0}}, count_ff};
            mul_b = {{(MUL_W-PHALF_W){1'b0}}, pval[PHALF_W-1:0]};
         end
         OP_COV_HI: begin
            mul_a = {{(MUL_W-COUNT_W){1'b0}}, count_ff};
            mul_b = MUL_W'($signed(pval[PSUM_W-1:PHALF_W]));
         end
         OP_COV_SS: begin
            mul_a = MUL_W'(sum_ff[cmd.row]);
            mul_b = MUL_W'(sum_ff[cmd.col]);
         end
         OP_DMUL: begin
            mul_a = {{(MUL_W-ROOT_W){1'b0}}, amp_root_ff[cmd.row]};
            mul_b = {{(MUL_W-ROOT_W){1'b0}}, amp_root_ff[cmd.col]};
         end
         default: ;
      endcase
   end

   assign srem_sh = {srem_ff[ROOT_W:0], rad_ff[COV_W-1:COV_W-2]};
   assign strial  = {1'b0, root_ff, 2'b01};
   assign drem_sh = {drem_ff, 1'b0};
   assign mag     = acc_ff[COV_W-1] ? (~acc_ff + COV_W'(1)) : acc_ff;
   assign mq      = big_ff ? CORR_ONE : CORR_W'(({1'b0, q_ff} + 16'd1) >> 1);
   assign ok      = (count_ff != '0) && diag_ok_ff[cmd.row] && diag_ok_ff[cmd.col];

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 4'(MAX_MODES);
         idx_ff       <= '0;
         count_ff     <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < MAX_MODES; n++) begin
            sum_ff[n] <= '0;
         end
      end else begin
         rsp_valid_ff <= (cmd.op == OP_EMIT);
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         case (cmd.op)
            OP_LOAD: begin
               if (status.complete) begin
                  idx_ff <= '0;
                  if (!status.saturated) begin
                     count_ff <= count_ff + COUNT_W'(1);
                  end
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            OP_MAC_RD: begin
               if (cmd.col == '0) begin
                  sum_ff[cmd.row] <= sum_ff[cmd.row] + SUM_W'(vs_ff[cmd.row]);
               end
            end
            OP_MAC_WR: vld_ff[addr] <= 1'b1;
            OP_CLEAR: begin
               idx_ff   <= '0;
               count_ff <= '0;
               vld_ff   <= '0;
               for (int n = 0; n < MAX_MODES; n++) begin
                  sum_ff[n] <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // cross-product memory
   always_ff @(posedge clock) begin
      if (cmd.op == OP_MAC_WR) begin
         psum_mem[addr] <= pval + PSUM_W'(mul_ff);
      end
      if (cmd.op == OP_MAC_RD || cmd.op == OP_COV_RD) begin
         rd_data_ff <= psum_mem[addr];
         rd_vld_ff  <= vld_ff[addr];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      case (cmd.op)
         OP_LOAD:    vs_ff[idx_ff] <= req_data.amplitude;
         OP_COV_HI:  acc_ff <= COV_W'(mul_ff);
         OP_COV_SS:  acc_ff <= acc_ff + (COV_W'(mul_ff) << PHALF_W);
         OP_COV_SUB: acc_ff <= acc_ff - COV_W'(mul_ff);
         OP_ISQ_LOAD: begin
            rad_ff    <= acc_ff;
            root_ff   <= '0;
            srem_ff   <= '0;
            isq_ok_ff <= !acc_ff[COV_W-1] && (acc_ff != '0);
         end
         OP_ISQ_STEP: begin
            rad_ff <= rad_ff << 2;
            if (srem_sh >= strial) begin
               srem_ff <= srem_sh - strial;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_ff <= srem_sh;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
         OP_ISQ_STORE: begin
            amp_root_ff[cmd.row] <= root_ff;
            diag_ok_ff[cmd.row]  <= isq_ok_ff;
         end
         OP_DIV_LOAD: begin
            neg_ff  <= acc_ff[COV_W-1];
            div_ff  <= COV_W'(mul_ff);
            big_ff  <= mag >= COV_W'(mul_ff);
            drem_ff <= mag;
            q_ff    <= '0;
         end
         OP_DIV_STEP: begin
            if (drem_sh >= {1'b0, div_ff}) begin
               drem_ff <= COV_W'(drem_sh - {1'b0, div_ff});
               q_ff    <= {q_ff[DIV_STEPS-2:0], 1'b1};
            end else begin
               drem_ff <= COV_W'(drem_sh);
               q_ff    <= {q_ff[DIV_STEPS-2:0], 1'b0};
            end
         end
         OP_EMIT: begin
            rsp_ff.row           <= 3'(cmd.row);
            rsp_ff.column        <= 3'(cmd.col);
            rsp_ff.zero_variance <= !ok;
            rsp_ff.last          <= ({1'b0, cmd.row} == modes - MCNT_W'(1)) &&
                                    ({1'b0, cmd.col} == modes - MCNT_W'(1));
            if (!ok) begin
               rsp_ff.correlation <= '0;
            end else if (neg_ff) begin
               rsp_ff.correlation <= -$signed(mq);
            end else begin
               rsp_ff.correlation <= $signed(mq);
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[design/cme_checker.sv]
// ----------------------------------------------------------------------------
// cme_checker
// Port-level checks of the correlation matrix engine.
// ----------------------------------------------------------------------------
module cme_checker import cme_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat while idle");

   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result beats");

   a_zero_corr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_variance |-> rsp_data.correlation == '0)
      else $error("zero variance with nonzero correlation");

   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.correlation <= $signed(CORR_ONE)) &&
                    (rsp_data.correlation >= -$signed(CORR_ONE)))
      else $error("correlation outside plus or minus one");

endmodule

bind correlation_matrix_engine cme_checker u_cme_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

[test/correlation_matrix_engine_tb.sv]
// ----------------------------------------------------------------------------
// correlation_matrix_engine_tb
// Self-checking bench for the correlation matrix engine: a predictor keeps the
// running sums of mode amplitudes and computes the expected Pearson matrix at
// each end-of-data beat; every result beat is matched against it in order.
// Directed sets cover extremes, flat modes, empty sets and mode count changes;
// random sets of mixed shape follow under varying idling.
// ----------------------------------------------------------------------------
module correlation_matrix_engine_tb;
   import cme_pkg::*;

   localparam int LIMIT = 2_000_000;

   // Predictor and store of expected matrix entries
   class correlation_predictor;
      bit [3:0]       mode_reg;
      longint         vec[MAX_MODES];
      int unsigned    pos;
      longint         count;
      longint         vsum[MAX_MODES];
      longint         psum[MAX_MODES*MAX_MODES];
      rsp_type        pending_entries[$];
      int             errors;

      function void clear_sums();
         pos = 0;
         count = 0;
         foreach (vsum[i]) vsum[i] = 0;
         foreach (psum[i]) psum[i] = 0;
      endfunction

      function void reset_state();
         mode_reg = 4'd8;
         foreach (vec[i]) vec[i] = 0;
         clear_sums();
         pending_entries.delete();
      endfunction

      function int active_modes();
         if (mode_reg == 0) return 1;
         if (mode_reg > MAX_MODES) return MAX_MODES;
         return mode_reg;
      endfunction

      function bit [63:0] int_root(bit [63:0] v);
         bit [63:0] res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= res + b) begin
               v -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      function longint scaled_cov(int i, int j);
         return count * psum[i*MAX_MODES+j] - vsum[i] * vsum[j];
      endfunction

      // Accepted request beat: fold it into the sums; on end of data, predict
      function void note_beat(req_type d);
         int m, idx;
         longint cii, cjj, cij;
         bit [63:0] mag, dv, rem, q, mq;
         bit neg;
         rsp_type e;
         m = active_modes();
         idx = pos & (MAX_MODES - 1);
         vec[idx] = longint'(d.amplitude);
         if (idx + 1 >= m) begin
            if (count < MAX_SAMPLES) begin
               count++;
               for (int i = 0; i < m; i++) begin
                  vsum[i] += vec[i];
                  for (int j = 0; j < m; j++)
                     psum[i*MAX_MODES+j] += vec[i] * vec[j];
               end
            end
            pos = 0;
         end else begin
            pos = idx + 1;
         end
         if (!d.end_of_data) return;
         for (int i = 0; i < m; i++) begin
            for (int j = 0; j < m; j++) begin
               cii = scaled_cov(i, i);
               cjj = scaled_cov(j, j);
               cij = scaled_cov(i, j);
               e.row = i[2:0];
               e.column = j[2:0];
               e.correlation = '0;
               e.zero_variance = 1'b1;
               e.last = (i + 1 == m && j + 1 == m);
               if (count != 0 && cii > 0 && cjj > 0) begin
                  neg = cij < 0;
                  mag = neg ? -cij : cij;
                  dv = int_root(cii) * int_root(cjj);
                  e.zero_variance = 1'b0;
                  if (mag / dv >= 1) begin
                     mq = 16384;
                  end else begin
                     rem = mag % dv;
                     q = 0;
                     for (int k = 0; k < DIV_STEPS; k++) begin
                        rem <<= 1;
                        q <<= 1;
                        if (rem >= dv) begin
                           rem -= dv;
                           q |= 1;
                        end
                     end
                     mq = (q + 1) >> 1;
                     if (mq > 16384) mq = 16384;
                  end
                  e.correlation = neg ? -mq[15:0] : mq[15:0];
               end
               pending_entries.push_back(e);
            end
         end
         clear_sums();
      endfunction

      function void check_entry(rsp_type got);
         rsp_type exp;
         if (pending_entries.size() == 0) begin
            errors++;
            $display("%0t: unexpected entry r%0d c%0d corr %0d zv %0b last %0b", $time,
                     got.row, got.column, got.correlation, got.zero_variance, got.last);
            return;
         end
         exp = pending_entries.pop_front();
         if (got.row !== exp.row || got.column !== exp.column ||
             got.correlation !== exp.correlation ||
             got.zero_variance !== exp.zero_variance || got.last !== exp.last) begin
            errors++;
            $display("%0t: expected r%0d c%0d corr %0d zv %0b last %0b", $time,
                     exp.row, exp.column, exp.correlation, exp.zero_variance, exp.last);
            $display("%0t: actual   r%0d c%0d corr %0d zv %0b last %0b", $time,
                     got.row, got.column, got.correlation, got.zero_variance, got.last);
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_we = 1'b0;
   logic [3:0] csr_wdata = 4'd0;

   correlation_predictor board = new();
   int sender_idle = 0;   // percent of cycles the sender holds off
   int beats_sent = 0;
   int cycles = 0;

   correlation_matrix_engine uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung block ends the run here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("correlation_matrix_engine: mismatch");
         $finish;
      end
   end

   // Every result beat is live for one cycle only; take it at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_entry(rsp_data);
   end

   // Drive one request beat; entered and left at a falling edge. Start stays
   // high on exit so a back-to-back beat needs no second assignment.
   task automatic send_beat(input logic signed [15:0] amp, input logic eod);
      req_type d;
      d.amplitude = amp;
      d.end_of_data = eod;
      while ($urandom_range(99) < sender_idle) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= d;
      do @(posedge clock); while (busy);
      board.note_beat(d);
      beats_sent++;
      @(negedge clock);
   endtask

   // Drop start and wait until every expected entry is in and the block idles
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (busy || board.pending_entries.size() != 0);
      @(negedge clock);
   endtask

   task automatic write_modes(input logic [3:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      board.mode_reg = v;
   endtask

   function automatic logic signed [15:0] pick_amp(int shape, logic signed [15:0] base);
      case (shape)
         0: pick_amp = 16'($urandom());                                // full range
         1: pick_amp = $signed(16'($urandom_range(0, 4000))) - 16'sd2000; // small
         2: pick_amp = base + $signed(16'($urandom_range(0, 60))) - 16'sd30; // tracks
         3: pick_amp = -base;                                          // anti-tracks
         default: pick_amp = 16'sd1234;                                // flat mode
      endcase
   endfunction

   // One data set of well-formed vectors; sometimes broken off mid-vector
   task automatic send_set();
      int m, nvec, broken, shape;
      logic signed [15:0] base, a;
      m = board.active_modes();
      nvec = $urandom_range(1, 4);
      broken = ($urandom_range(99) < 15);
      for (int v = 0; v < nvec; v++) begin
         base = 16'($urandom());
         for (int k = 0; k < m; k++) begin
            shape = (k == 0) ? $urandom_range(0, 1) : $urandom_range(0, 4);
            a = (k == 0) ? (shape == 0 ? base : pick_amp(1, 16'sd0)) : pick_amp(shape, base);
            if (k == 0) base = a;
            if (broken && v == nvec - 1 && k == m / 2) begin
               send_beat(a, 1'b1);   // end inside a vector: drop the partial one
               return;
            end
            send_beat(a, v == nvec - 1 && k == m - 1);
         end
      end
   endtask

   initial begin
      board.reset_state();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty set at reset width: a lone partial vector, so no samples at all
      send_beat(16'sd5, 1'b1);

      // Amplitude extremes on two modes, near-perfectly anti-correlated
      write_modes(4'd2);
      send_beat(16'sh7FFF, 1'b0); send_beat(-16'sh8000, 1'b0);
      send_beat(-16'sh8000, 1'b0); send_beat(16'sh7FFF, 1'b0);
      send_beat(16'sd0, 1'b0);     send_beat(16'sd0, 1'b1);

      // Flat first mode: zero variance flags on its row and column
      send_beat(16'sd5, 1'b0); send_beat(16'sd1, 1'b0);
      send_beat(16'sd5, 1'b0); send_beat(16'sd2, 1'b0);
      send_beat(16'sd5, 1'b0); send_beat(16'sd3, 1'b1);

      // Identical modes: full positive correlation
      send_beat(16'sd100, 1'b0); send_beat(16'sd100, 1'b0);
      send_beat(-16'sd7, 1'b0);  send_beat(-16'sd7, 1'b1);

      // Shrink the mode count mid-vector; the vector closes on the next beat
      write_modes(4'd3);
      send_beat(16'sd40, 1'b0); send_beat(-16'sd9, 1'b0);
      write_modes(4'd1);
      send_beat(16'sd300, 1'b0); send_beat(-16'sd300, 1'b1);

      // Out-of-range mode counts: zero acts as one, above eight acts as eight
      write_modes(4'd0);
      send_beat(16'sd11, 1'b0); send_beat(-16'sd11, 1'b1);
      write_modes(4'd15);
      for (int k = 0; k < 8; k++) send_beat(16'($urandom()), 1'b0);
      for (int k = 0; k < 7; k++) send_beat(16'($urandom()), 1'b0);
      send_beat(16'($urandom()), 1'b1);

      // Random sets in three idling phases, mode count sometimes changed between sets
      beats_sent = 0;
      for (int ph = 0; ph < 3; ph++) begin
         sender_idle = (ph == 0) ? 21 : (ph == 1) ? 68 : 0;
         write_modes(ph == 0 ? 4'd8 : ph == 1 ? 4'd1 : 4'd5);
         while (beats_sent < 40 * (ph + 1)) begin
            if ($urandom_range(99) < 30) begin
               if ($urandom_range(9) == 0) write_modes(4'($urandom_range(0, 15)));
               else write_modes(4'($urandom_range(1, 8)));
            end
            send_set();
         end
      end

      // Let the last matrix come out, then allow a short tail
      drain();
      repeat (50) @(posedge clock);
      if (board.errors == 0 && board.pending_entries.size() == 0) begin
         $display("correlation_matrix_engine: match");
      end else begin
         $display("correlation_matrix_engine: mismatch");
      end
      $finish;
   end

endmodule
